### src/pit_pkg.sv
`timescale 1ns / 1ps
package pit_pkg;

  localparam int KEY_W      = 64;
  localparam int FACE_W     = 6;
  localparam int NOW_W      = 32;
  localparam int RTT_W      = 31;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 1;
  localparam int MASK_W     = 64;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_RTT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK = 1'b1;

  // Item kinds
  localparam logic ACT_INTEREST = 1'b0;
  localparam logic ACT_DATA     = 1'b1;

  // Classified item as it travels from front to back
  typedef struct packed {
    logic              action;
    logic [KEY_W-1:0]  key;
    logic [FACE_W-1:0] face;
    logic              timer_expired;
    logic              cacheable;
    logic [NOW_W-1:0]  now;
  } item_t;

  typedef struct packed {
    logic              pending_found;
    logic [63:0]       faces;
    logic              entry_cacheable;
    logic [NOW_W-1:0]  entry_time;
    logic              table_full;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_EXEC
  } state_t;

endpackage

### src/pit_if.sv
`timescale 1ns / 1ps
// Input channel: one interest or data item per transfer
interface pit_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] chunk_tag;
  logic [5:0]  arrival_face;
  logic        timer_expired;
  logic        cacheable;
  logic [31:0] now;

  modport source (output valid, action, chunk_tag, arrival_face, timer_expired,
                  cacheable, now, input ready);
  modport sink (input valid, action, chunk_tag, arrival_face, timer_expired,
                cacheable, now, output ready);
endinterface

// Result channel: one result per accepted item
interface pit_out_if;
  logic        valid;
  logic        ready;
  logic        pending_found;
  logic [63:0] faces;
  logic        entry_cacheable;
  logic [31:0] entry_time;
  logic        table_full;

  modport source (output valid, pending_found, faces, entry_cacheable, entry_time,
                  table_full, input ready);
  modport sink (input valid, pending_found, faces, entry_cacheable, entry_time,
                table_full, output ready);
endinterface

### src/pit_front.sv
`timescale 1ns / 1ps
module pit_front (
  input  logic                  clk,
  input  logic                  rst,
  pit_in_if.sink                item,
  input  logic [63:0]           mask,
  output logic                  push_valid,
  input  logic                  push_ready,
  output pit_pkg::item_t        push_item
);
  import pit_pkg::*;

  logic  held;
  item_t held_item;

  // Input register: free when empty or when its item moves on this cycle
  assign item.ready = !held || push_ready;
  assign push_valid = held;
  assign push_item  = held_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (item.ready) begin
      held <= item.valid;
    end
  end

  // Key is the chunk identifier with representation bits cleared
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      held_item.action        <= item.action;
      held_item.key           <= item.chunk_tag & ~mask;
      held_item.face          <= item.arrival_face;
      held_item.timer_expired <= item.timer_expired;
      held_item.cacheable     <= item.cacheable;
      held_item.now           <= item.now;
    end
  end

endmodule

### src/pit_fifo.sv
`timescale 1ns / 1ps
module pit_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  pit_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output pit_pkg::item_t pop_item
);
  import pit_pkg::*;

  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

### src/pit_back.sv
`timescale 1ns / 1ps
module pit_back #(
  parameter int ENTRIES    = 256,
  parameter int FACE_COUNT = 64,
  parameter int TIME_BITS  = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [pit_pkg::RTT_W-1:0]   rtt,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  pit_pkg::item_t              pop_item,
  pit_out_if.source                   result
);
  import pit_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

  // Table storage
  logic                  valid_mem [ENTRIES];
  logic [KEY_W-1:0]      key_mem   [ENTRIES];
  logic [TIME_BITS-1:0]  stamp_mem [ENTRIES];
  logic [FACE_COUNT-1:0] faces_mem [ENTRIES];
  logic                  flag_mem  [ENTRIES];

  state_t                st;
  state_t                st_next;
  logic [IW:0]           cnt;
  item_t                 cur;
  logic                  cmp_vld;
  logic [IW-1:0]         cmp_idx;
  logic                  hit;
  logic [IW-1:0]         hit_idx;
  logic                  free;
  logic [IW-1:0]         free_idx;
  logic [IW-1:0]         slot;
  logic                  valid_q;
  logic [KEY_W-1:0]      key_q;
  logic [TIME_BITS-1:0]  stamp_q;
  logic [FACE_COUNT-1:0] faces_q;
  logic                  flag_q;
  logic                  res_valid;
  result_t               res_data;

  logic                  issue;
  logic [IW-1:0]         rd_addr;
  logic                  out_free;
  logic                  fire;
  logic                  is_data;
  logic [TIME_BITS-1:0]  now_t;
  logic [CW-1:0]         age;
  logic [CW-1:0]         two_rtt;
  logic                  stale;
  logic                  fresh;
  logic                  full;
  logic [FACE_COUNT-1:0] face_bits;
  logic                  valid_we;
  logic                  valid_wd;
  logic [IW-1:0]         valid_wa;
  logic                  ent_we;
  logic                  faces_we;
  logic [FACE_COUNT-1:0] faces_wd;
  result_t               res_next;

  // Item decode and ageing
  assign is_data   = (cur.action == ACT_DATA);
  assign now_t     = TIME_BITS'(cur.now);
  assign age       = CW'(TIME_BITS'(now_t - stamp_q));
  assign two_rtt   = CW'({rtt, 1'b0});
  assign stale     = (age > two_rtt);
  assign fresh     = !hit || cur.timer_expired || stale;
  assign full      = !hit && !free;
  assign face_bits = (7'(cur.face) < 7'(FACE_COUNT)) ? (FACE_COUNT'(1) << cur.face) : '0;
  assign faces_wd  = (fresh ? '0 : faces_q) | face_bits;
  assign out_free  = !res_valid || result.ready;

  // Next state
  always_comb begin
    st_next = st;
    unique case (st)
      ST_CLEAR: if (cnt == (IW+1)'(ENTRIES - 1)) st_next = ST_IDLE;
      ST_IDLE:  if (pop_valid) st_next = ST_SCAN;
      ST_SCAN:  if (cnt == (IW+1)'(ENTRIES)) st_next = ST_FETCH;
      ST_FETCH: st_next = ST_EXEC;
      ST_EXEC:  if (out_free) st_next = ST_IDLE;
      default:  st_next = ST_CLEAR;
    endcase
  end

  // Controls per state
  always_comb begin
    pop_ready = 1'b0;
    issue     = 1'b0;
    rd_addr   = slot;
    fire      = 1'b0;
    unique case (st)
      ST_CLEAR: ;
      ST_IDLE:  pop_ready = 1'b1;
      ST_SCAN: begin
        issue   = (cnt != (IW+1)'(ENTRIES));
        rd_addr = cnt[IW-1:0];
      end
      ST_FETCH: rd_addr = hit ? hit_idx : free_idx;
      ST_EXEC:  fire = out_free;
      default:  ;
    endcase
  end

  // Table writes and the result of the item under execution
  always_comb begin
    valid_we = 1'b0;
    valid_wd = 1'b0;
    valid_wa = slot;
    ent_we   = 1'b0;
    faces_we = 1'b0;
    res_next = '0;
    if (st == ST_CLEAR) begin
      valid_we = 1'b1;
      valid_wa = cnt[IW-1:0];
    end else if (fire) begin
      if (is_data) begin
        valid_we = hit;
        res_next.pending_found   = hit;
        res_next.faces           = hit ? 64'(faces_q) : '0;
        res_next.entry_cacheable = hit && flag_q;
        res_next.entry_time      = hit ? NOW_W'(stamp_q) : '0;
      end else begin
        valid_we = !full;
        valid_wd = 1'b1;
        ent_we   = !full && fresh;
        faces_we = !full;
        res_next.pending_found = !fresh;
        res_next.table_full    = full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) st <= ST_CLEAR;
    else     st <= st_next;
  end

  // Sweep counter, scan bookkeeping and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      cmp_vld   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (st == ST_CLEAR) cnt <= cnt + 1'b1;
      if (pop_ready && pop_valid) begin
        cnt     <= '0;
        cmp_vld <= 1'b0;
      end else if (st == ST_SCAN) begin
        cmp_vld <= issue;
        if (issue) cnt <= cnt + 1'b1;
      end
      if (fire)              res_valid <= 1'b1;
      else if (result.ready) res_valid <= 1'b0;
    end
  end

  // Match and lowest free slot, one entry a cycle
  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      cur  <= pop_item;
      hit  <= 1'b0;
      free <= 1'b0;
    end else if (cmp_vld) begin
      if (valid_q && key_q == cur.key && !hit) begin
        hit     <= 1'b1;
        hit_idx <= cmp_idx;
      end
      if (!valid_q && !free) begin
        free     <= 1'b1;
        free_idx <= cmp_idx;
      end
    end
    if (issue) cmp_idx <= cnt[IW-1:0];
    if (st == ST_FETCH) slot <= rd_addr;
    if (fire) res_data <= res_next;
  end

  // Memories: one registered read address, one write address
  always_ff @(posedge clk) begin
    valid_q <= valid_mem[rd_addr];
    key_q   <= key_mem[rd_addr];
    stamp_q <= stamp_mem[rd_addr];
    faces_q <= faces_mem[rd_addr];
    flag_q  <= flag_mem[rd_addr];
    if (valid_we) valid_mem[valid_wa] <= valid_wd;
    if (ent_we) begin
      key_mem[slot]   <= cur.key;
      stamp_mem[slot] <= now_t;
      flag_mem[slot]  <= cur.cacheable;
    end
    if (faces_we) faces_mem[slot] <= faces_wd;
  end

  assign result.valid           = res_valid;
  assign result.pending_found   = res_data.pending_found;
  assign result.faces           = res_data.faces;
  assign result.entry_cacheable = res_data.entry_cacheable;
  assign result.entry_time      = res_data.entry_time;
  assign result.table_full      = res_data.table_full;

endmodule

### src/pending_interest_table.sv
`timescale 1ns / 1ps
// Pending interest table.
// The item channel takes interests (action 0) and data arrivals (action 1);
// the result channel returns exactly one result per item, in order.
// Configuration writes (cfg_we, cfg_index, cfg_data) set the round trip
// time (index 0) and the representation mask (index 1); the user writes
// them only while idle, and the block itself does not enforce this.
// The front registers each item and clears the representation bits from
// its chunk id, then places it in a two-deep queue. The back pops one item
// at a time and scans the table, one entry a cycle through the key memory
// port, for the matching key and the lowest free slot; it then reads the
// entry, updates it and loads the output register.
// An item's time in the back, and its latency from transfer in to result,
// grow with ENTRIES; the sequential scan sets them.
// After reset the back clears the valid bits of all ENTRIES entries, one
// entry a cycle, and takes no item meanwhile.
// A stalled result channel holds the result in the output register; the
// queue and input register keep taking up to three more items.
module pending_interest_table #(
  parameter int ENTRIES    = 256,
  parameter int FACE_COUNT = 64,
  parameter int TIME_BITS  = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pit_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pit_pkg::CFG_DATA_W-1:0]    cfg_data,
  pit_in_if.sink                            item,
  pit_out_if.source                         result
);
  import pit_pkg::*;

  logic [RTT_W-1:0]  rtt;
  logic [MASK_W-1:0] representation_mask;
  logic              f_valid;
  logic              f_ready;
  item_t             f_item;
  logic              q_valid;
  logic              q_ready;
  item_t             q_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rtt                 <= '0;
      representation_mask <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RTT:  rtt                 <= cfg_data[RTT_W-1:0];
        CFG_MASK: representation_mask <= cfg_data[MASK_W-1:0];
        default:  ;
      endcase
    end
  end

  pit_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .mask       (representation_mask),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item)
  );

  pit_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  pit_back #(
    .ENTRIES    (ENTRIES),
    .FACE_COUNT (FACE_COUNT),
    .TIME_BITS  (TIME_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .rtt       (rtt),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_item  (q_item),
    .result    (result)
  );

endmodule
